[rtl/core/range_scan_object_segmenter_core_macros.svh]
// Assertion macros shared by the range scan segmenter RTL.
`ifndef RANGE_SCAN_OBJECT_SEGMENTER_CORE_MACROS_SVH
`define RANGE_SCAN_OBJECT_SEGMENTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSOS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rsos_pkg.sv]
// Types, constants and smoothing/segmentation functions of the range scan segmenter.
package rsos_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int DIST_W      = 14;
	localparam int OIDX_W      = 12;
	localparam int COUNT_W     = 12;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [OIDX_W-1:0]  oidx_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam idx_t   IDX_LAST  = IDX_W'(MAX_SAMPLES - 1);
	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
	localparam dist_t  THR_RESET = DIST_W'(100);

	typedef enum logic [0:0] {
		CFG_SPIKE_THRESHOLD = 1'b0,
		CFG_JUMP_THRESHOLD  = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		REC_OBJECT = 1'b0,
		REC_DONE   = 1'b1
	} rec_kind_t;

	typedef struct packed {
		dist_t spike;
		dist_t jump;
	} thr_t;

	typedef struct packed {
		rec_kind_t kind;
		oidx_t     start_index;
		oidx_t     end_index;
		dist_t     min_distance;
		count_t    object_count;
		logic      last;
	} rec_t;

	typedef struct packed {
		logic [1:0] n;
		rec_t       rec0;
		rec_t       rec1;
	} push_t;

	typedef struct packed {
		logic   obj_open;
		idx_t   start;
		dist_t  run_min;
		count_t found;
		dist_t  prev;
	} seg_state_t;

	typedef struct packed {
		seg_state_t st;
		logic       emit;
		rec_t       rec;
	} seg_result_t;

	// Reduce a sample index to the 12-bit output field
	function automatic oidx_t idx_out(idx_t i);
		logic [31:0] w;
		w = 32'(i);
		return w[OIDX_W-1:0];
	endfunction

	// Spike filter: replace an outlier by the floor mean of previous and next
	function automatic dist_t smooth_sample(logic first, dist_t raw, dist_t nxt,
		dist_t prev, dist_t thr);
		dist_t         diff;
		logic [DIST_W:0] sum;
		diff = (raw > prev) ? raw - prev : prev - raw;
		sum  = {1'b0, prev} + {1'b0, nxt};
		if (!first && diff > thr) begin
			return sum[DIST_W:1];
		end
		return raw;
	endfunction

	// One segmentation step on a smoothed sample
	function automatic seg_result_t segment_sample(idx_t idx, dist_t c, seg_state_t s,
		dist_t thr);
		seg_result_t r;
		r      = '0;
		r.st   = s;
		r.emit = 1'b0;
		if (idx != '0) begin
			if (s.prev > c && (s.prev - c) > thr) begin
				r.st.obj_open = 1'b1;
				r.st.start    = idx;
				r.st.run_min  = c;
			end
			if (r.st.obj_open && c < r.st.run_min) begin
				r.st.run_min = c;
			end
			if (c > s.prev && (c - s.prev) > thr && r.st.obj_open) begin
				if (r.st.found != COUNT_MAX) begin
					r.st.found = r.st.found + COUNT_W'(1);
				end
				r.emit             = 1'b1;
				r.rec.kind         = REC_OBJECT;
				r.rec.start_index  = idx_out(r.st.start);
				r.rec.end_index    = idx_out(idx - IDX_W'(1));
				r.rec.min_distance = r.st.run_min;
				r.rec.object_count = r.st.found;
				r.rec.last         = 1'b0;
				r.st.obj_open      = 1'b0;
			end
		end
		r.st.prev = c;
		return r;
	endfunction

	// Scan summary record
	function automatic rec_t done_rec(count_t n);
		rec_t r;
		r              = '0;
		r.kind         = REC_DONE;
		r.object_count = n;
		r.last         = 1'b1;
		return r;
	endfunction

endpackage

[rtl/core/rsos_if.sv]
// Channel interfaces: sample input, result output and register write.
interface rsos_sample_if;
	logic          valid;
	logic          ready;
	rsos_pkg::dist_t distance;
	modport source (output valid, output distance, input ready);
	modport sink   (input valid, input distance, output ready);
endinterface

interface rsos_result_if;
	logic             valid;
	logic             ready;
	logic             record_kind;
	rsos_pkg::oidx_t  start_index;
	rsos_pkg::oidx_t  end_index;
	rsos_pkg::dist_t  min_distance;
	rsos_pkg::count_t object_count;
	logic             last_of_run;
	modport source (output valid, output record_kind, output start_index, output end_index,
		output min_distance, output object_count, output last_of_run, input ready);
	modport sink   (input valid, input record_kind, input start_index, input end_index,
		input min_distance, input object_count, input last_of_run, output ready);
endinterface

interface rsos_cfg_if;
	logic               valid;
	logic               ready;
	rsos_pkg::cfg_reg_t index;
	rsos_pkg::dist_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/rsos_cfg_regs.sv]
// Threshold registers written through the configuration channel.
module rsos_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	rsos_cfg_if.sink        cfg,
	output rsos_pkg::thr_t  thr
);

	rsos_pkg::thr_t thr_q;

	assign cfg.ready = 1'b1;
	assign thr       = thr_q;

	// Decode the register index and load the addressed threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.spike <= rsos_pkg::THR_RESET;
			thr_q.jump  <= rsos_pkg::THR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rsos_pkg::CFG_SPIKE_THRESHOLD: thr_q.spike <= cfg.data;
				rsos_pkg::CFG_JUMP_THRESHOLD:  thr_q.jump  <= cfg.data;
				default:                       thr_q       <= thr_q;
			endcase
		end
	end

endmodule

[rtl/core/rsos_step.sv]
// Per-item datapath: spike filter, segmentation and scan state.
`include "range_scan_object_segmenter_core_macros.svh"

module rsos_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  rsos_pkg::dist_t distance,
	input  rsos_pkg::thr_t  thr,
	output rsos_pkg::push_t push
);

	rsos_pkg::dist_t      pend_raw_q;
	logic                 pend_valid_q;
	rsos_pkg::idx_t       idx_q;
	rsos_pkg::seg_state_t st_q;

	logic                  end_scan;
	logic                  at_limit;
	logic                  done_needed;
	logic                  obj_emit;
	rsos_pkg::dist_t       next_a;
	rsos_pkg::dist_t       c_a;
	rsos_pkg::dist_t       c_b;
	rsos_pkg::seg_result_t seg_a;
	rsos_pkg::seg_result_t seg_b;
	rsos_pkg::seg_state_t  st_1;
	rsos_pkg::idx_t        idx_1;
	rsos_pkg::rec_t        obj_rec;
	rsos_pkg::rec_t        fin_rec;

	// Finish the pending sample now that its successor is known
	assign end_scan = (distance == '0);
	assign next_a   = end_scan ? '0 : distance;
	assign c_a      = rsos_pkg::smooth_sample(idx_q == '0, pend_raw_q, next_a, st_q.prev,
		thr.spike);
	assign seg_a    = rsos_pkg::segment_sample(idx_q, c_a, st_q, thr.jump);
	assign st_1     = pend_valid_q ? seg_a.st : st_q;
	assign idx_1    = pend_valid_q ? idx_q + rsos_pkg::IDX_W'(1) : idx_q;

	// Close the scan at the last index: the new sample has no successor
	assign at_limit = !end_scan && (idx_1 >= rsos_pkg::IDX_LAST);
	assign c_b      = rsos_pkg::smooth_sample(idx_1 == '0, distance, '0, st_1.prev,
		thr.spike);
	assign seg_b    = rsos_pkg::segment_sample(idx_1, c_b, st_1, thr.jump);

	// Assemble up to two records, the summary always last
	always_comb begin
		done_needed = end_scan || at_limit;
		obj_emit    = (pend_valid_q && seg_a.emit) || (at_limit && seg_b.emit);
		obj_rec     = (pend_valid_q && seg_a.emit) ? seg_a.rec : seg_b.rec;
		obj_rec.last = !done_needed;
		fin_rec     = rsos_pkg::done_rec(end_scan ? st_1.found : seg_b.st.found);
		push.n      = accept ? 2'({1'b0, obj_emit} + {1'b0, done_needed}) : 2'd0;
		push.rec0   = obj_emit ? obj_rec : fin_rec;
		push.rec1   = fin_rec;
	end

	// Advance scan state, or clear it once the summary goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_raw_q   <= '0;
			pend_valid_q <= 1'b0;
			idx_q        <= '0;
			st_q         <= '0;
		end else if (accept) begin
			if (done_needed) begin
				pend_raw_q   <= '0;
				pend_valid_q <= 1'b0;
				idx_q        <= '0;
				st_q         <= '0;
			end else begin
				pend_raw_q   <= distance;
				pend_valid_q <= 1'b1;
				idx_q        <= idx_1;
				st_q         <= st_1;
			end
		end
	end

	`RSOS_ASSERT_NOW(a_idx_below_last, pend_valid_q, idx_q < rsos_pkg::IDX_LAST,
		"pending sample index reached the scan limit")
	`RSOS_ASSERT_NOW(a_pair_order, push.n == 2'd2,
		push.rec0.kind == rsos_pkg::REC_OBJECT && push.rec1.kind == rsos_pkg::REC_DONE,
		"two records must be an object followed by the summary")
	`RSOS_ASSERT_NEXT(a_scan_cleared, accept && end_scan, !pend_valid_q && idx_q == '0,
		"scan state not cleared after end of scan")

endmodule

[rtl/core/rsos_result_fifo.sv]
// Three-entry result queue taking up to two records per cycle.
`include "range_scan_object_segmenter_core_macros.svh"

module rsos_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  rsos_pkg::push_t push,
	output logic            space,
	rsos_result_if.source   results
);

	localparam int DEPTH = 3;

	rsos_pkg::rec_t slot_q [DEPTH];
	rsos_pkg::rec_t slot_d [DEPTH];
	logic [1:0]     cnt_q;
	logic [1:0]     base;
	logic           pop;

	// Room for a worst-case pair while the head may still be stalled
	assign space = (cnt_q <= 2'd1);
	assign pop   = (cnt_q != 2'd0) && results.ready;
	assign base  = cnt_q - 2'({1'b0, pop});

	// Shift out the head, then append the new records behind the survivors
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (pop && i < DEPTH - 1) begin
				slot_d[i] = slot_q[i+1];
			end else begin
				slot_d[i] = slot_q[i];
			end
			if (push.n != 2'd0 && 2'(i) == base) begin
				slot_d[i] = push.rec0;
			end else if (push.n == 2'd2 && 2'(i) == base + 2'd1) begin
				slot_d[i] = push.rec1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			slot_q[i] <= slot_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + push.n;
		end
	end

	assign results.valid        = (cnt_q != 2'd0);
	assign results.record_kind  = 1'(slot_q[0].kind);
	assign results.start_index  = slot_q[0].start_index;
	assign results.end_index    = slot_q[0].end_index;
	assign results.min_distance = slot_q[0].min_distance;
	assign results.object_count = slot_q[0].object_count;
	assign results.last_of_run  = slot_q[0].last;

	`RSOS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= 2'd3, "result queue overfilled")
	`RSOS_ASSERT_NEXT(a_pair_queued, push.n == 2'd2, cnt_q >= 2'd2,
		"record pair not held in the queue")
	`RSOS_ASSERT_NOW(a_follower_present, results.valid && !results.last_of_run,
		cnt_q >= 2'd2, "non-final record at head without its follower")

endmodule

[rtl/core/range_scan_object_segmenter_core.sv]
// Top level of the range scan object segmenter.
//
// Usage:
//   samples : one raw range sample per item (distance). Zero ends the scan;
//             the sample with the last index also ends it.
//   results : object records (start, end, minimum, count) and one summary
//             record per scan; last_of_run marks the final record of a sample.
//   cfg     : register writes, index 0 spike threshold, index 1 jump threshold.
//             Always ready; write only while no records are outstanding.
// Timing:
//   A sample is filtered and segmented when its successor arrives, so its
//   records leave with the next sample. Records caused by an accepted sample
//   are valid on results in the following cycle unless earlier records wait.
//   One sample per cycle is taken while results.ready is high and each sample
//   produces at most one record; a sample producing two records holds off the
//   next, as the single output port drains the three-entry result queue.
// Reset: thresholds return to 100, scan state and queue are emptied.
// Stall: the queue holds records while results.ready is low; samples.ready
//   drops once two or more records are waiting.
module range_scan_object_segmenter_core (
	input  logic          clk,
	input  logic          arst_n,
	rsos_sample_if.sink   samples,
	rsos_result_if.source results,
	rsos_cfg_if.sink      cfg
);

	rsos_pkg::thr_t  thr;
	rsos_pkg::push_t push;
	logic            space;
	logic            accept;

	assign samples.ready = space;
	assign accept        = samples.valid && space;

	rsos_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.thr    (thr)
	);

	rsos_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.distance (samples.distance),
		.thr      (thr),
		.push     (push)
	);

	rsos_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.space   (space),
		.results (results)
	);

endmodule

[test/tb_range_scan_object_segmenter_core.sv]
// Self-checking testbench of the range scan object segmenter: directed and random scans.
`timescale 1ns / 100ps

module tb_range_scan_object_segmenter_core;

	logic clk = 1'b0;
	logic arst_n;

	rsos_sample_if sample_ch();
	rsos_result_if result_ch();
	rsos_cfg_if    cfg_ch();

	range_scan_object_segmenter_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	// Predicted scan state and thresholds
	rsos_pkg::dist_t  spike_thr;
	rsos_pkg::dist_t  jump_thr;
	rsos_pkg::dist_t  held_raw;
	bit               held_valid;
	rsos_pkg::dist_t  last_smooth;
	int unsigned      scan_idx;
	bit               in_object;
	int unsigned      obj_start;
	rsos_pkg::dist_t  obj_min;
	rsos_pkg::count_t obj_count;

	rsos_pkg::rec_t step_records[$];
	rsos_pkg::rec_t expected_records[$];

	int  mismatch_count = 0;
	int  samples_sent   = 0;
	bit  calm           = 1'b0;
	bit  hold_results   = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Spike filter of one raw sample against the last smoothed value
	function automatic rsos_pkg::dist_t filter_sample(int unsigned idx, rsos_pkg::dist_t raw,
		rsos_pkg::dist_t nxt);
		rsos_pkg::dist_t gap;
		logic [14:0]     total;
		if (idx == 0) begin
			return raw;
		end
		gap   = (raw > last_smooth) ? raw - last_smooth : last_smooth - raw;
		total = {1'b0, last_smooth} + {1'b0, nxt};
		if (gap > spike_thr) begin
			return total[14:1];
		end
		return raw;
	endfunction

	// Open, track and close objects on one smoothed sample
	task automatic track_objects(int unsigned idx, rsos_pkg::dist_t c);
		rsos_pkg::rec_t r;
		if (idx != 0) begin
			if (last_smooth > c && last_smooth - c > jump_thr) begin
				in_object = 1'b1;
				obj_start = idx;
				obj_min   = c;
			end
			if (in_object && c < obj_min) begin
				obj_min = c;
			end
			if (c > last_smooth && c - last_smooth > jump_thr && in_object) begin
				if (obj_count != rsos_pkg::COUNT_MAX) begin
					obj_count++;
				end
				r              = '0;
				r.kind         = rsos_pkg::REC_OBJECT;
				r.start_index  = rsos_pkg::oidx_t'(obj_start);
				r.end_index    = rsos_pkg::oidx_t'(idx - 1);
				r.min_distance = obj_min;
				r.object_count = obj_count;
				step_records.push_back(r);
				in_object = 1'b0;
			end
		end
		last_smooth = c;
	endtask

	// Emit the summary record and return scan state to its reset value
	task automatic close_scan();
		rsos_pkg::rec_t r;
		r              = '0;
		r.kind         = rsos_pkg::REC_DONE;
		r.object_count = obj_count;
		step_records.push_back(r);
		held_raw    = '0;
		held_valid  = 1'b0;
		last_smooth = '0;
		scan_idx    = 0;
		in_object   = 1'b0;
		obj_start   = 0;
		obj_min     = '0;
		obj_count   = '0;
	endtask

	// Work out the records that one accepted sample causes
	task automatic predict_scan_step(rsos_pkg::dist_t d);
		step_records.delete();
		if (d == '0) begin
			if (held_valid) begin
				track_objects(scan_idx, filter_sample(scan_idx, held_raw, '0));
			end
			close_scan();
		end else begin
			if (held_valid) begin
				track_objects(scan_idx, filter_sample(scan_idx, held_raw, d));
				scan_idx++;
			end
			held_raw   = d;
			held_valid = 1'b1;
			if (scan_idx >= rsos_pkg::MAX_SAMPLES - 1) begin
				track_objects(scan_idx, filter_sample(scan_idx, d, '0));
				close_scan();
			end
		end
		if (step_records.size() > 0) begin
			step_records[$].last = 1'b1;
		end
		foreach (step_records[i]) begin
			expected_records.push_back(step_records[i]);
		end
	endtask

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Compare each accepted record with the oldest expectation
	always @(posedge clk) begin : check_records
		rsos_pkg::rec_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_records.size() == 0) begin
				flag_mismatch("record with none expected, kind", result_ch.record_kind, 0);
			end else begin
				want = expected_records.pop_front();
				if (result_ch.record_kind !== want.kind)
					flag_mismatch("record_kind", result_ch.record_kind, want.kind);
				if (result_ch.start_index !== want.start_index)
					flag_mismatch("start_index", result_ch.start_index, want.start_index);
				if (result_ch.end_index !== want.end_index)
					flag_mismatch("end_index", result_ch.end_index, want.end_index);
				if (result_ch.min_distance !== want.min_distance)
					flag_mismatch("min_distance", result_ch.min_distance, want.min_distance);
				if (result_ch.object_count !== want.object_count)
					flag_mismatch("object_count", result_ch.object_count, want.object_count);
				if (result_ch.last_of_run !== want.last)
					flag_mismatch("last_of_run", result_ch.last_of_run, want.last);
			end
		end
	end

	// Drive result ready: random stall bursts, long hold-off on request
	initial begin : drain_results
		int stall;
		stall           = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 5);
			end
			if (hold_results || stall > 0) begin
				result_ch.ready <= 1'b0;
				if (stall > 0) begin
					stall--;
				end
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one sample, with an optional idle burst first, and wait for acceptance
	task automatic send_sample(rsos_pkg::dist_t d);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.distance <= d;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		predict_scan_step(d);
		samples_sent++;
	endtask

	// Drop sample valid, drain all expected records and let the pipeline empty
	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_records.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(rsos_pkg::cfg_reg_t which, rsos_pkg::dist_t value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (which == rsos_pkg::CFG_SPIKE_THRESHOLD) begin
			spike_thr = value;
		end else begin
			jump_thr = value;
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic rsos_pkg::dist_t pick_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return rsos_pkg::dist_t'($urandom_range(0, 16383));
			default: return rsos_pkg::dist_t'($urandom_range(10, 600));
		endcase
	endfunction

	// Send one scan of background and object levels with jitter and spikes
	task automatic send_scan(int unsigned len, bit closed);
		int          base;
		int          level;
		int          v;
		int unsigned sel;
		bit          near;
		base  = $urandom_range(200, 16383);
		level = base;
		near  = 1'b0;
		for (int unsigned k = 0; k < len; k++) begin
			sel = $urandom_range(0, 15);
			if (sel < 3) begin
				near  = !near;
				level = near ? $urandom_range(1, base) : base;
			end
			if (sel == 3) begin
				v = $urandom_range(1, 16383);
			end else if (sel == 4) begin
				v = $urandom_range(1, 8);
			end else begin
				v = level + $urandom_range(0, 20) - 10;
				if (v < 1) v = 1;
				if (v > 16383) v = 16383;
			end
			send_sample(rsos_pkg::dist_t'(v));
		end
		if (closed) begin
			send_sample('0);
		end
	endtask

	// Unstructured samples, with the odd zero ending a scan
	task automatic send_noise(int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_sample('0);
			end else begin
				send_sample(rsos_pkg::dist_t'($urandom_range(0, 16383)));
			end
		end
	endtask

	// Reset thresholds: empty scan, extremes, spike at scan end averaged with zero
	task automatic test_reset_thresholds();
		int seq[11] = '{0, 16383, 16383, 1, 1, 16383, 16383, 1, 1, 5000, 0};
		foreach (seq[i]) send_sample(rsos_pkg::dist_t'(seq[i]));
		settle();
	endtask

	// No spikes, any step is a jump: restart while open, open object at end
	task automatic test_open_and_restart();
		int seq[9] = '{200, 100, 50, 60, 40, 300, 300, 100, 0};
		write_threshold(rsos_pkg::CFG_SPIKE_THRESHOLD, '1);
		write_threshold(rsos_pkg::CFG_JUMP_THRESHOLD, '0);
		foreach (seq[i]) send_sample(rsos_pkg::dist_t'(seq[i]));
		settle();
	endtask

	// Every step is a spike and no step is a jump
	task automatic test_all_spikes();
		int seq[4] = '{16383, 1, 16383, 0};
		write_threshold(rsos_pkg::CFG_SPIKE_THRESHOLD, '0);
		write_threshold(rsos_pkg::CFG_JUMP_THRESHOLD, '1);
		foreach (seq[i]) send_sample(rsos_pkg::dist_t'(seq[i]));
		settle();
	endtask

	// A scan that ends by reaching the last sample index
	task automatic test_full_length_scan();
		write_threshold(rsos_pkg::CFG_SPIKE_THRESHOLD, 14'd300);
		write_threshold(rsos_pkg::CFG_JUMP_THRESHOLD, 14'd150);
		send_scan(rsos_pkg::MAX_SAMPLES, 1'b0);
		settle();
	endtask

	// Hold results off while objects keep coming, so the input stalls
	task automatic test_output_backpressure();
		write_threshold(rsos_pkg::CFG_SPIKE_THRESHOLD, '1);
		write_threshold(rsos_pkg::CFG_JUMP_THRESHOLD, 14'd50);
		fork
			begin
				hold_results = 1'b1;
				repeat (300) @(posedge clk);
				hold_results = 1'b0;
			end
		join_none
		for (int k = 0; k < 40; k++) begin
			send_sample((k % 2 == 0) ? 14'd1000 : 14'd100);
		end
		send_sample('0);
		settle();
	endtask

	// Random scans and noise under changing thresholds
	task automatic test_random_scans(int unsigned count);
		int first;
		int scans;
		first = samples_sent;
		scans = 0;
		while (samples_sent - first < count) begin
			if (scans % 4 == 0) begin
				settle();
				write_threshold(rsos_pkg::CFG_SPIKE_THRESHOLD, pick_threshold());
				write_threshold(rsos_pkg::CFG_JUMP_THRESHOLD, pick_threshold());
			end
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) == 0) begin
				send_noise($urandom_range(1, 20));
			end else begin
				send_scan($urandom_range(1, 40), 1'b1);
			end
			scans++;
		end
		calm = 1'b0;
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_calm_tail();
		settle();
		write_threshold(rsos_pkg::CFG_SPIKE_THRESHOLD, 14'd200);
		write_threshold(rsos_pkg::CFG_JUMP_THRESHOLD, 14'd100);
		calm = 1'b1;
		repeat (3) send_scan($urandom_range(10, 25), 1'b1);
	endtask

	initial begin
		arst_n             = 1'b0;
		sample_ch.valid    = 1'b0;
		sample_ch.distance = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = rsos_pkg::CFG_SPIKE_THRESHOLD;
		cfg_ch.data        = '0;
		spike_thr          = rsos_pkg::THR_RESET;
		jump_thr           = rsos_pkg::THR_RESET;
		step_records.delete();
		close_scan();
		step_records.delete();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_thresholds();
		test_open_and_restart();
		test_all_spikes();
		test_full_length_scan();
		test_output_backpressure();
		test_random_scans(440);
		test_calm_tail();

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("range_scan_object_segmenter_core verification clean");
		end else begin
			$display("range_scan_object_segmenter_core verification failed");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("range_scan_object_segmenter_core verification failed");
		$finish;
	end

endmodule

[range_scan_object_segmenter_core.f]
+incdir+rtl/core
rtl/core/rsos_pkg.sv
rtl/core/rsos_if.sv
rtl/core/rsos_cfg_regs.sv
rtl/core/rsos_step.sv
rtl/core/rsos_result_fifo.sv
rtl/core/range_scan_object_segmenter_core.sv
test/tb_range_scan_object_segmenter_core.sv
